// ----- rtl/contrast_clamp_white_centroid_defines.svh -----
// assertion macros for the contrast clamp white centroid block
`ifndef CONTRAST_CLAMP_WHITE_CENTROID_DEFINES_SVH
`define CONTRAST_CLAMP_WHITE_CENTROID_DEFINES_SVH

`ifndef SYNTHESIS
`define CCWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ccwc assertion failed");
`define CCWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ccwc assertion failed");
`else
`define CCWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CCWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/ccwc_pkg.sv -----
`timescale 1ns / 1ps

package ccwc_pkg;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 12;
	localparam int SUM_W      = 36;
	localparam int CNT_W      = 25;
	localparam int GAIN_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int STEP_W     = $clog2(SUM_W);

	localparam logic [CFG_IDX_W-1:0] CFG_PIVOT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;

	localparam logic [PIX_W-1:0]  PIVOT_RST = 8'd210;
	localparam logic [GAIN_W-1:0] GAIN_RST  = 4'd3;
	localparam logic [PIX_W-1:0]  PIX_MAX   = 8'd255;

	typedef struct packed {
		logic [PIX_W-1:0]   red_in;
		logic [PIX_W-1:0]   green_in;
		logic [PIX_W-1:0]   blue_in;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               frame_end;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0]   red_out;
		logic [PIX_W-1:0]   green_out;
		logic [PIX_W-1:0]   blue_out;
		logic               is_white;
		logic [COORD_W-1:0] centroid_x;
		logic [COORD_W-1:0] centroid_y;
		logic               centroid_valid;
		logic               frame_done;
	} result_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             is_white;
		logic             frame_done;
		logic [SUM_W-1:0] col_sum;
		logic [SUM_W-1:0] row_sum;
		logic [CNT_W-1:0] count;
	} entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} bk_state_t;

endpackage

// ----- rtl/contrast_clamp_white_centroid.sv -----
`timescale 1ns / 1ps

// path: an accepted pixel word is written to the queue, then registered into the result output
// throughput: one word per cycle while full stays low; a frame end word with white pixels
//   holds the back part in the 36 step shared centroid divider, a 4 word queue buffers
// reset: asynchronous, clears queue, accumulators and result valid flag; pivot 210, gain 3
module contrast_clamp_white_centroid #(
	parameter int COORD_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ccwc_pkg::pixel_t                pixel,
	input  logic                            push,
	output logic                            full,
	output ccwc_pkg::result_t               result,
	output logic                            empty,
	input  logic                            pop,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ccwc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccwc_pkg::PIX_W-1:0]      cfg_data
);
	import ccwc_pkg::*;

	logic   fifo_wr;
	logic   fifo_full;
	logic   fifo_pop;
	logic   fifo_empty;
	entry_t fifo_wdata;
	entry_t fifo_head;

	ccwc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.push      (push),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fifo_wr   (fifo_wr),
		.fifo_data (fifo_wdata),
		.fifo_full (fifo_full)
	);

	ccwc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fifo_wr),
		.wr_data (fifo_wdata),
		.full    (fifo_full),
		.rd      (fifo_pop),
		.rd_data (fifo_head),
		.empty   (fifo_empty)
	);

	ccwc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (fifo_head),
		.fifo_empty (fifo_empty),
		.fifo_pop   (fifo_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// ----- rtl/ccwc_front.sv -----
`timescale 1ns / 1ps

module ccwc_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ccwc_pkg::pixel_t                pixel,
	input  logic                            push,
	output logic                            full,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ccwc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccwc_pkg::PIX_W-1:0]      cfg_data,
	output logic                            fifo_wr,
	output ccwc_pkg::entry_t                fifo_data,
	input  logic                            fifo_full
);
	import ccwc_pkg::*;

	localparam int UsedBits = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int MaskVal  = (1 << UsedBits) - 1;
	localparam logic [COORD_W-1:0] CoordMask = COORD_W'(MaskVal);

	logic [PIX_W-1:0]   pivot_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [SUM_W-1:0]   col_sum_q;
	logic [SUM_W-1:0]   row_sum_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   col_sum_nx;
	logic [SUM_W-1:0]   row_sum_nx;
	logic [CNT_W-1:0]   count_nx;
	logic [PIX_W-1:0]   red_adj;
	logic [PIX_W-1:0]   green_adj;
	logic [PIX_W-1:0]   blue_adj;
	logic [COORD_W-1:0] col_m;
	logic [COORD_W-1:0] row_m;
	logic               white;
	logic               accept;

	function automatic logic [PIX_W-1:0] stretch(
		input logic [PIX_W-1:0]  c,
		input logic [PIX_W-1:0]  p,
		input logic [GAIN_W-1:0] g
	);
		logic signed [9:0]  d;
		logic signed [14:0] v;
		logic [PIX_W-1:0]   r;
		d = $signed({2'b00, c}) - $signed({2'b00, p});
		v = 15'(d) * 15'($signed({1'b0, g})) + 15'($signed({2'b00, p}));
		if (v > 15'sd255) begin
			r = PIX_MAX;
		end else if (v < 15'sd0) begin
			r = '0;
		end else begin
			r = v[PIX_W-1:0];
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign full      = fifo_full;
	assign accept    = push && !fifo_full;

	assign red_adj   = stretch(pixel.red_in, pivot_q, gain_q);
	assign green_adj = stretch(pixel.green_in, pivot_q, gain_q);
	assign blue_adj  = stretch(pixel.blue_in, pivot_q, gain_q);
	assign white     = (red_adj == PIX_MAX) && (green_adj == PIX_MAX) && (blue_adj == PIX_MAX);
	assign col_m     = pixel.column & CoordMask;
	assign row_m     = pixel.row & CoordMask;

	always_comb begin
		col_sum_nx = col_sum_q;
		row_sum_nx = row_sum_q;
		count_nx   = count_q;
		if (white) begin
			col_sum_nx = col_sum_q + SUM_W'(col_m);
			row_sum_nx = row_sum_q + SUM_W'(row_m);
			count_nx   = count_q + CNT_W'(1);
		end
	end

	always_comb begin
		fifo_wr              = accept;
		fifo_data.red        = red_adj;
		fifo_data.green      = green_adj;
		fifo_data.blue       = blue_adj;
		fifo_data.is_white   = white;
		fifo_data.frame_done = pixel.frame_end;
		fifo_data.col_sum    = col_sum_nx;
		fifo_data.row_sum    = row_sum_nx;
		fifo_data.count      = count_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q <= PIVOT_RST;
			gain_q  <= GAIN_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_PIVOT) begin
				pivot_q <= cfg_data;
			end else if (cfg_index == CFG_GAIN) begin
				gain_q <= cfg_data[GAIN_W-1:0];
			end
		end
	end

	// accumulators clear after the frame end word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_sum_q <= '0;
			row_sum_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (pixel.frame_end) begin
				col_sum_q <= '0;
				row_sum_q <= '0;
				count_q   <= '0;
			end else begin
				col_sum_q <= col_sum_nx;
				row_sum_q <= row_sum_nx;
				count_q   <= count_nx;
			end
		end
	end

endmodule

// ----- rtl/ccwc_fifo.sv -----
`timescale 1ns / 1ps

module ccwc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  ccwc_pkg::entry_t wr_data,
	output logic             full,
	input  logic             rd,
	output ccwc_pkg::entry_t rd_data,
	output logic             empty
);
	import ccwc_pkg::*;

	entry_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr && !full) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd && !empty) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr && !full, rd && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/ccwc_back.sv -----
`timescale 1ns / 1ps

`include "contrast_clamp_white_centroid_defines.svh"

module ccwc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ccwc_pkg::entry_t  head,
	input  logic              fifo_empty,
	output logic              fifo_pop,
	output ccwc_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);
	import ccwc_pkg::*;

	bk_state_t          state_q;
	bk_state_t          state_nx;
	entry_t             hold_q;
	result_t            out_q;
	logic               out_valid_q;
	logic [SUM_W-1:0]   dvd_x_q;
	logic [SUM_W-1:0]   dvd_y_q;
	logic [CNT_W-1:0]   dsr_q;
	logic [CNT_W-1:0]   rem_x_q;
	logic [CNT_W-1:0]   rem_y_q;
	logic [COORD_W-1:0] qx_q;
	logic [COORD_W-1:0] qy_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [CNT_W:0]     trial_x;
	logic [CNT_W:0]     trial_y;
	logic [CNT_W:0]     diff_x;
	logic [CNT_W:0]     diff_y;
	logic               ge_x;
	logic               ge_y;
	logic               out_free;
	logic               needs_div;
	logic               out_load;
	logic               out_from_div;
	logic               div_load;
	logic               div_step;

	assign out_free  = !out_valid_q || pop;
	assign needs_div = head.frame_done && (head.count != '0);
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!fifo_empty && needs_div) begin
					state_nx = BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_nx = BK_FIN;
				end
			end
			BK_FIN: begin
				if (out_free) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		fifo_pop     = 1'b0;
		out_load     = 1'b0;
		out_from_div = 1'b0;
		div_load     = 1'b0;
		div_step     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!fifo_empty) begin
					if (needs_div) begin
						fifo_pop = 1'b1;
						div_load = 1'b1;
					end else if (out_free) begin
						fifo_pop = 1'b1;
						out_load = 1'b1;
					end
				end
			end
			BK_DIV: div_step = 1'b1;
			BK_FIN: begin
				out_load     = out_free;
				out_from_div = 1'b1;
			end
			default: ;
		endcase
	end

	// restoring division, one quotient bit a cycle, both sums share the divisor
	assign trial_x = {rem_x_q, dvd_x_q[SUM_W-1]};
	assign trial_y = {rem_y_q, dvd_y_q[SUM_W-1]};
	assign ge_x    = trial_x >= {1'b0, dsr_q};
	assign ge_y    = trial_y >= {1'b0, dsr_q};
	assign diff_x  = trial_x - {1'b0, dsr_q};
	assign diff_y  = trial_y - {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (div_load) begin
			hold_q  <= head;
			dvd_x_q <= head.col_sum;
			dvd_y_q <= head.row_sum;
			dsr_q   <= head.count;
			rem_x_q <= '0;
			rem_y_q <= '0;
			qx_q    <= '0;
			qy_q    <= '0;
		end else if (div_step) begin
			dvd_x_q <= {dvd_x_q[SUM_W-2:0], 1'b0};
			dvd_y_q <= {dvd_y_q[SUM_W-2:0], 1'b0};
			rem_x_q <= ge_x ? diff_x[CNT_W-1:0] : trial_x[CNT_W-1:0];
			rem_y_q <= ge_y ? diff_y[CNT_W-1:0] : trial_y[CNT_W-1:0];
			qx_q    <= {qx_q[COORD_W-2:0], ge_x};
			qy_q    <= {qy_q[COORD_W-2:0], ge_y};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (div_load) begin
				cnt_q <= STEP_W'(SUM_W - 1);
			end else if (div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (out_from_div) begin
				out_q.red_out        <= hold_q.red;
				out_q.green_out      <= hold_q.green;
				out_q.blue_out       <= hold_q.blue;
				out_q.is_white       <= hold_q.is_white;
				out_q.centroid_x     <= qx_q;
				out_q.centroid_y     <= qy_q;
				out_q.centroid_valid <= 1'b1;
				out_q.frame_done     <= 1'b1;
			end else begin
				out_q.red_out        <= head.red;
				out_q.green_out      <= head.green;
				out_q.blue_out       <= head.blue;
				out_q.is_white       <= head.is_white;
				out_q.centroid_x     <= '0;
				out_q.centroid_y     <= '0;
				out_q.centroid_valid <= 1'b0;
				out_q.frame_done     <= head.frame_done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	`CCWC_ASSERT_IMP(a_no_overwrite, clk, arst_n, out_load, !out_valid_q || pop)
	`CCWC_ASSERT_IMP(a_pop_nonempty, clk, arst_n, fifo_pop, !fifo_empty)
	`CCWC_ASSERT_NXT(a_div_finish, clk, arst_n, state_q == BK_DIV && cnt_q == '0, state_q == BK_FIN)
	`CCWC_ASSERT_NXT(a_fin_valid, clk, arst_n, state_q == BK_FIN && out_free, out_valid_q && out_q.centroid_valid)

endmodule

// ----- verif/ccwc_checker.sv -----
`timescale 1ns / 1ps

module ccwc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ccwc_pkg::pixel_t               pixel,
	input  logic                           push,
	input  logic                           full,
	input  ccwc_pkg::result_t              result,
	input  logic                           empty,
	input  logic                           pop,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [ccwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ccwc_pkg::PIX_W-1:0]     cfg_data,
	output int                             errors,
	output int                             pending
);
	import ccwc_pkg::*;

	logic [PIX_W-1:0]  pivot;
	logic [GAIN_W-1:0] gain;
	logic [SUM_W-1:0]  column_acc;
	logic [SUM_W-1:0]  row_acc;
	logic [CNT_W-1:0]  white_cnt;
	result_t           adjusted_words[$];
	result_t           want;
	result_t           got;
	int                mismatches;

	function automatic logic [PIX_W-1:0] stretch_level(input logic [PIX_W-1:0] level);
		int v;
		v = (int'(level) - int'(pivot)) * int'(gain) + int'(pivot);
		if (v > 255) v = 255;
		if (v < 0) v = 0;
		return v[PIX_W-1:0];
	endfunction

	task automatic stretch_and_accumulate(input pixel_t p, output result_t r);
		logic [SUM_W-1:0] quot;
		r = '0;
		r.red_out   = stretch_level(p.red_in);
		r.green_out = stretch_level(p.green_in);
		r.blue_out  = stretch_level(p.blue_in);
		r.is_white  = (r.red_out == PIX_MAX) && (r.green_out == PIX_MAX)
			&& (r.blue_out == PIX_MAX);
		if (r.is_white) begin
			column_acc = column_acc + SUM_W'(p.column);
			row_acc    = row_acc + SUM_W'(p.row);
			white_cnt  = white_cnt + 1'b1;
		end
		if (p.frame_end) begin
			r.frame_done = 1'b1;
			if (white_cnt != '0) begin
				quot = column_acc / SUM_W'(white_cnt);
				r.centroid_x = quot[COORD_W-1:0];
				quot = row_acc / SUM_W'(white_cnt);
				r.centroid_y = quot[COORD_W-1:0];
				r.centroid_valid = 1'b1;
			end
			column_acc = '0;
			row_acc    = '0;
			white_cnt  = '0;
		end
	endtask

	task automatic check_field(input string name, input longint unsigned exp_v,
		input longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot      = PIVOT_RST;
			gain       = GAIN_RST;
			column_acc = '0;
			row_acc    = '0;
			white_cnt  = '0;
			mismatches = 0;
			adjusted_words.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_PIVOT: pivot = cfg_data;
					CFG_GAIN:  gain = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				stretch_and_accumulate(pixel, want);
				adjusted_words.push_back(want);
			end
			if (pop && !empty) begin
				got = result;
				if (adjusted_words.size() == 0) begin
					$display("%0t ns: word expected none actual %h", $time, got);
					mismatches++;
				end else begin
					want = adjusted_words.pop_front();
					check_field("red_out", want.red_out, got.red_out);
					check_field("green_out", want.green_out, got.green_out);
					check_field("blue_out", want.blue_out, got.blue_out);
					check_field("is_white", want.is_white, got.is_white);
					check_field("centroid_x", want.centroid_x, got.centroid_x);
					check_field("centroid_y", want.centroid_y, got.centroid_y);
					check_field("centroid_valid", want.centroid_valid, got.centroid_valid);
					check_field("frame_done", want.frame_done, got.frame_done);
				end
			end
			errors  <= mismatches;
			pending <= adjusted_words.size();
		end
	end

endmodule

// ----- verif/tb_contrast_clamp_white_centroid.sv -----
`timescale 1ns / 1ps

module tb_contrast_clamp_white_centroid;
	import ccwc_pkg::*;

	localparam int                   STALL_LIMIT = 4000;
	localparam int                   TAIL        = 8;
	localparam int                   PHASE_WORDS = 206;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	pixel_t               pixel;
	logic                 push;
	logic                 full;
	result_t              result;
	logic                 empty;
	logic                 pop;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PIX_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   stall = 0;
	logic [PIX_W-1:0]     cur_pivot = PIVOT_RST;
	int                   push_run = 0;
	bit                   push_busy = 1'b0;

	always #5 clk = ~clk;

	contrast_clamp_white_centroid i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.push      (push),
		.full      (full),
		.result    (result),
		.empty     (empty),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ccwc_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.push      (push),
		.full      (full),
		.result    (result),
		.empty     (empty),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall <= 0;
		end else begin
			stall <= stall + 1;
		end
		if (stall >= STALL_LIMIT) begin
			$display("** contrast_clamp_white_centroid: FAILED **");
			$finish;
		end
	end

	function automatic pixel_t make_pixel(input int r, input int g, input int b,
		input int c, input int rw, input bit e);
		pixel_t p;
		p.red_in    = PIX_W'(r);
		p.green_in  = PIX_W'(g);
		p.blue_in   = PIX_W'(b);
		p.column    = COORD_W'(c);
		p.row       = COORD_W'(rw);
		p.frame_end = e;
		return p;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		unique case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// bright pixels are biased towards the white threshold, some keep one channel free
	function automatic pixel_t random_pixel();
		pixel_t           p;
		logic [PIX_W-1:0] lv[3];
		int               kind;
		int               odd;
		kind = $urandom_range(0, 9);
		odd  = $urandom_range(0, 2);
		for (int ch = 0; ch < 3; ch++) begin
			if (kind < 6 && !(kind >= 4 && ch == odd)) begin
				lv[ch] = ($urandom_range(0, 2) == 0) ? PIX_MAX
					: PIX_W'($urandom_range(int'(cur_pivot), 255));
			end else begin
				lv[ch] = PIX_W'($urandom);
			end
		end
		p.red_in    = lv[0];
		p.green_in  = lv[1];
		p.blue_in   = lv[2];
		p.column    = pick_coord();
		p.row       = pick_coord();
		p.frame_end = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	task automatic send_pixel(input pixel_t p);
		int gap;
		if (push_run == 0) begin
			push_run  = $urandom_range(20, 80);
			push_busy = ($urandom_range(0, 2) == 0);
		end
		push_run--;
		gap = push_busy ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic run_phase(input logic [PIX_W-1:0] piv, input logic [GAIN_W-1:0] gn);
		drain();
		write_reg(CFG_PIVOT, piv);
		write_reg(CFG_GAIN, {GAIN_W'($urandom), gn});
		cfg_valid <= 1'b0;
		cur_pivot = piv;
		repeat (PHASE_WORDS) send_pixel(random_pixel());
	endtask

	initial begin : result_sink
		int gap;
		int run;
		bit busy;
		run  = 0;
		busy = 1'b0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (run == 0) begin
				run  = $urandom_range(20, 80);
				busy = ($urandom_range(0, 2) == 0);
			end
			run--;
			gap = busy ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		arst_n    <= 1'b0;
		push      <= 1'b0;
		pixel     <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: white from level 225 upwards
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
		send_pixel(make_pixel(255, 255, 255, 4095, 4095, 0));
		send_pixel(make_pixel(225, 225, 225, 0, 0, 0));
		send_pixel(make_pixel(224, 225, 225, 1, 1, 0));
		send_pixel(make_pixel(210, 210, 210, 100, 200, 0));
		send_pixel(make_pixel(255, 255, 0, 5, 6, 0));
		send_pixel(make_pixel(0, 255, 255, 7, 8, 0));
		send_pixel(make_pixel(255, 0, 255, 9, 10, 1));
		send_pixel(make_pixel(1, 2, 3, 11, 12, 1));
		send_pixel(make_pixel(255, 255, 255, 7, 9, 1));
		send_pixel(make_pixel(240, 250, 230, 4095, 0, 0));
		send_pixel(make_pixel(255, 255, 255, 0, 4095, 0));
		send_pixel(make_pixel(226, 226, 226, 2048, 2048, 0));
		send_pixel(make_pixel(100, 150, 209, 3, 4, 1));
		send_pixel(make_pixel(211, 209, 255, 1365, 2730, 0));
		send_pixel(make_pixel(128, 64, 32, 2730, 1365, 0));
		send_pixel(make_pixel(255, 255, 255, 4095, 4095, 1));
		send_pixel(make_pixel(255, 255, 255, 1, 1, 1));
		send_pixel(make_pixel(0, 0, 0, 0, 0, 1));

		// unused register indexes
		drain();
		write_reg(CFG_SPARE_A, PIX_W'($urandom));
		write_reg(CFG_SPARE_B, PIX_W'($urandom));
		cfg_valid <= 1'b0;

		run_phase(8'd255, 4'd0);
		run_phase(8'd0, 4'd0);
		run_phase(8'd0, 4'd15);
		run_phase(8'd255, 4'd15);
		run_phase(8'd128, 4'd1);
		run_phase(PIVOT_RST, GAIN_RST);
		run_phase(PIX_W'($urandom), GAIN_W'($urandom));
		run_phase(PIX_W'($urandom_range(180, 250)), GAIN_W'($urandom_range(1, 6)));
		drain();

		if (errors == 0 && pending == 0) begin
			$display("** contrast_clamp_white_centroid: PASSED **");
		end else begin
			$display("** contrast_clamp_white_centroid: FAILED **");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ccwc_pkg.sv
rtl/ccwc_front.sv
rtl/ccwc_fifo.sv
rtl/ccwc_back.sv
rtl/contrast_clamp_white_centroid.sv
verif/ccwc_checker.sv
verif/tb_contrast_clamp_white_centroid.sv
